@@ rtl/plim_pkg.sv @@
// ----------------------------------------------------------------------------
// plim_pkg
// Shared types and constants for the PDO power limiter pipeline.
// ----------------------------------------------------------------------------
package plim_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned NUM_W   = 16;
    localparam int unsigned VOLT_W  = 8;
    localparam int unsigned CUR_W   = 10;
    localparam int unsigned BUDG_W  = 8;
    localparam int unsigned BITS_PER_STAGE = 4;
    localparam int unsigned DIV_STAGES = NUM_W / BITS_PER_STAGE;

    localparam logic [1:0] PDO_TYPE_FIXED = 2'b00;

    // Fixed supply switches to a halved divisor above this budget
    localparam logic [BUDG_W-1:0] BUDGET_SPLIT = 8'd130;
    localparam logic [9:0]        FIX_SCALE_LO = 10'd500;
    localparam logic [9:0]        FIX_SCALE_HI = 10'd250;
    localparam logic [9:0]        PPS_SCALE    = 10'd100;

    // Coded programmable voltages and their values in 100 mV units
    localparam logic [VOLT_W-1:0] PPS_CODE_5V  = 8'd59;
    localparam logic [VOLT_W-1:0] PPS_CODE_9V  = 8'd110;
    localparam logic [VOLT_W-1:0] PPS_CODE_15V = 8'd160;
    localparam logic [VOLT_W-1:0] PPS_CODE_20V = 8'd210;
    localparam logic [VOLT_W-1:0] PPS_VAL_5V   = 8'd50;
    localparam logic [VOLT_W-1:0] PPS_VAL_9V   = 8'd90;
    localparam logic [VOLT_W-1:0] PPS_VAL_15V  = 8'd150;
    localparam logic [VOLT_W-1:0] PPS_VAL_20V  = 8'd200;

    localparam logic REG_BUDGET = 1'b0;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
        logic              bypass;
        logic              fixed;
        logic [CUR_W-1:0]  cur;
        logic [VOLT_W-1:0] div;
        logic [VOLT_W-1:0] rem;
        logic [NUM_W-1:0]  quo;
    } t_div_item;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } t_out_item;

endpackage

@@ rtl/plim_decode.sv @@
// ----------------------------------------------------------------------------
// plim_decode
// Pick voltage, current and numerator out of a capability word; registered.
// ----------------------------------------------------------------------------
module plim_decode (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [plim_pkg::BUDG_W-1:0]     i_budget,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [plim_pkg::WORD_W-1:0]     i_word,
    input  logic                            i_last,
    output logic                            o_valid,
    input  logic                            i_ready,
    output plim_pkg::t_div_item             o_item
);
    import plim_pkg::*;

    logic              r_valid;
    t_div_item         r_item;
    t_div_item         n_item;
    logic [VOLT_W-1:0] pps_volt;
    logic [VOLT_W-1:0] fix_volt;
    logic [NUM_W-1:0]  prod;
    logic              low_budget;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        pps_volt = i_word[24:17];
        if (pps_volt == PPS_CODE_5V) begin
            pps_volt = PPS_VAL_5V;
        end else if (pps_volt == PPS_CODE_9V) begin
            pps_volt = PPS_VAL_9V;
        end else if (pps_volt == PPS_CODE_15V) begin
            pps_volt = PPS_VAL_15V;
        end else if (pps_volt == PPS_CODE_20V) begin
            pps_volt = PPS_VAL_20V;
        end
        fix_volt   = i_word[18:11];
        low_budget = (i_budget <= BUDGET_SPLIT);

        n_item       = '0;
        n_item.word  = i_word;
        n_item.last  = i_last;
        n_item.fixed = (i_word[31:30] == PDO_TYPE_FIXED);
        // every budget times scale product fits in NUM_W bits
        if (n_item.fixed) begin
            n_item.cur = i_word[CUR_W-1:0];
            if (low_budget) begin
                prod       = NUM_W'(i_budget) * NUM_W'(FIX_SCALE_LO);
                n_item.div = fix_volt;
            end else begin
                prod       = NUM_W'(i_budget) * NUM_W'(FIX_SCALE_HI);
                n_item.div = {1'b0, fix_volt[VOLT_W-1:1]};
            end
        end else begin
            n_item.cur = {2'b00, i_word[7:0]};
            prod       = NUM_W'(i_budget) * NUM_W'(PPS_SCALE);
            n_item.div = pps_volt;
        end
        n_item.quo    = prod;
        n_item.bypass = (i_budget == '0) || (n_item.div == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ rtl/plim_div_stage.sv @@
// ----------------------------------------------------------------------------
// plim_div_stage
// Four restoring division steps on the numerator, registered.
// ----------------------------------------------------------------------------
module plim_div_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  plim_pkg::t_div_item i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output plim_pkg::t_div_item o_item
);
    import plim_pkg::*;

    logic        r_valid;
    t_div_item   r_item;
    t_div_item   n_item;
    logic [VOLT_W:0] shifted;
    logic        ge;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_item = i_item;
        for (int k = 0; k < BITS_PER_STAGE; k++) begin
            shifted = {n_item.rem, n_item.quo[NUM_W-1]};
            ge      = (shifted >= {1'b0, n_item.div});
            if (ge) begin
                shifted = shifted - {1'b0, n_item.div};
            end
            n_item.rem = shifted[VOLT_W-1:0];
            n_item.quo = {n_item.quo[NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ rtl/plim_merge.sv @@
// ----------------------------------------------------------------------------
// plim_merge
// Clamp the quotient to the original current and rebuild the word; bypass items pass unchanged.
// ----------------------------------------------------------------------------
module plim_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  plim_pkg::t_div_item i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output plim_pkg::t_out_item o_item
);
    import plim_pkg::*;

    logic             r_valid;
    t_out_item        r_item;
    t_out_item        n_item;
    logic [CUR_W-1:0] lim;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        if (i_item.quo > {{(NUM_W-CUR_W){1'b0}}, i_item.cur}) begin
            lim = i_item.cur;
        end else begin
            lim = i_item.quo[CUR_W-1:0];
        end
        n_item.last = i_item.last;
        if (i_item.bypass) begin
            n_item.word = i_item.word;
        end else if (i_item.fixed) begin
            n_item.word = {i_item.word[WORD_W-1:CUR_W], lim};
        end else begin
            n_item.word = {i_item.word[WORD_W-1:8], lim[7:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ rtl/pd_source_pdo_power_limiter.sv @@
// ----------------------------------------------------------------------------
// pd_source_pdo_power_limiter
// Derates the current field of USB PD source capability words to a budget.
// ----------------------------------------------------------------------------
// Pipeline from input accept to o_m_tvalid: decode, four divider stages of
//   four quotient bits each, then clamp and merge, each stage registered.
// Throughput: one item per cycle; each stage holds its item under backpressure
//   and empty stages fill while the output waits.
// Reset: synchronous, active low; clears all stage valids and the budget to 0.
module pd_source_pdo_power_limiter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] pdo_word
    input  logic        i_s_tlast,   // pdo_is_last
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] limited_pdo_word
    output logic        o_m_tlast    // limited_is_last
);
    import plim_pkg::*;

    logic [BUDG_W-1:0] r_budget;
    logic              wr_en;

    t_div_item         item   [DIV_STAGES+1];
    logic              valid  [DIV_STAGES+1];
    logic              ready  [DIV_STAGES+1];
    t_out_item         out_item;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_BUDGET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= '0;
        end else if (wr_en) begin
            r_budget <= i_pwdata[BUDG_W-1:0];
        end
    end

    always_comb begin
        if (i_paddr[2] == REG_BUDGET) begin
            o_prdata = {{(32-BUDG_W){1'b0}}, r_budget};
        end else begin
            o_prdata = '0;
        end
    end

    plim_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_budget (r_budget),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_word   (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_valid  (valid[0]),
        .i_ready  (ready[0]),
        .o_item   (item[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        plim_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid[g]),
            .o_ready (ready[g]),
            .i_item  (item[g]),
            .o_valid (valid[g+1]),
            .i_ready (ready[g+1]),
            .o_item  (item[g+1])
        );
    end

    plim_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (valid[DIV_STAGES]),
        .o_ready (ready[DIV_STAGES]),
        .i_item  (item[DIV_STAGES]),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_item  (out_item)
    );

    assign o_m_tdata = out_item.word;
    assign o_m_tlast = out_item.last;

endmodule
